### src/pstd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_pkg: shared types and constants of the Pruefer sequence decoder
// Sizes, codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pstd_pkg;

    localparam int MAX_NODES = 64;
    localparam int SEQ_DEPTH = MAX_NODES - 2;
    localparam int LABEL_W   = 6;
    localparam int NODE_W    = 7;
    localparam int DEG_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int SEQ_AW    = $clog2(SEQ_DEPTH);
    localparam int DEG_AW    = $clog2(MAX_NODES);

    // input opcodes
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_EDGE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TINY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

    // kinds of result the datapath loads into its output register
    localparam logic [1:0] EMIT_EDGE  = 2'd0;
    localparam logic [1:0] EMIT_FINAL = 2'd1;
    localparam logic [1:0] EMIT_TINY  = 2'd2;
    localparam logic [1:0] EMIT_BAD   = 2'd3;

    typedef struct packed {
        logic       push;
        logic       clr_run;
        logic       idx_clr;
        logic       idx_inc;
        logic       lab_ld;
        logic       deg_init_wr;
        logic       deg_rd_lab;
        logic       deg_wr_inc;
        logic       deg_wr_dec;
        logic       deg_wr_leaf_zero;
        logic       scan_start;
        logic       scan_run;
        logic       first_ld;
        logic       emit;
        logic [1:0] emit_kind;
    } cmd_t;

    typedef struct packed {
        logic pre_bad;
        logic n_le1;
        logic n_is2;
        logic seq_last;
        logic deg_last;
        logic lab_big;
        logic scan_end;
        logic out_free;
    } stat_t;

endpackage

### src/pstd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pstd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/pstd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_datapath: storage, counters and output register of the decoder
// Holds the label store, the degree table, the leaf scan and the result item.
// ----------------------------------------------------------------------------
module pstd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pstd_pkg::cmd_t                cmd,
    output pstd_pkg::stat_t               stat,
    input  logic [pstd_pkg::LABEL_W-1:0]  in_label,
    input  logic                          cfg_we,
    input  logic [pstd_pkg::NODE_W-1:0]   cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pstd_pkg::LABEL_W-1:0]  out_first,
    output logic [pstd_pkg::LABEL_W-1:0]  out_second,
    output logic [pstd_pkg::STATUS_W-1:0] out_status,
    output logic                          out_last
);

    import pstd_pkg::*;

    logic [NODE_W-1:0]   node_count_reg;
    logic [NODE_W-1:0]   pushed_count_reg, pushed_count_next;
    logic                bad_flag_reg, bad_flag_next;
    logic [DEG_AW-1:0]   idx_reg, idx_next;
    logic [LABEL_W-1:0]  lab_reg;
    logic [LABEL_W-1:0]  leaf_reg;
    logic [LABEL_W-1:0]  first_reg;
    logic [NODE_W-1:0]   scan_reg, scan_next;
    logic                pipe_vld_reg, pipe_vld_next;
    logic [DEG_AW-1:0]   pipe_addr_reg;
    logic                out_vld_reg, out_vld_next;
    logic [LABEL_W-1:0]  out_first_reg, out_second_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    logic                seq_we;
    logic [LABEL_W-1:0]  seq_rdata;
    logic                deg_we;
    logic [DEG_AW-1:0]   deg_waddr, deg_raddr;
    logic [DEG_W-1:0]    deg_wdata, deg_rdata;
    logic                store_full;
    logic                scan_issue, scan_found, scan_empty;

    assign store_full = (pushed_count_reg >= NODE_W'(SEQ_DEPTH));
    assign seq_we     = cmd.push && !store_full;

    pstd_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (SEQ_DEPTH)
    ) u_seq_ram (
        .clk   (clk),
        .we    (seq_we),
        .waddr (pushed_count_reg[SEQ_AW-1:0]),
        .wdata (in_label),
        .raddr (idx_reg[SEQ_AW-1:0]),
        .rdata (seq_rdata)
    );

    always_comb
    begin
        deg_we    = cmd.deg_init_wr || cmd.deg_wr_inc || cmd.deg_wr_dec
                    || cmd.deg_wr_leaf_zero;
        deg_waddr = leaf_reg;
        deg_wdata = '0;
        priority if (cmd.deg_init_wr)
        begin
            deg_waddr = idx_reg;
            deg_wdata = DEG_W'(NODE_W'(idx_reg) < node_count_reg);
        end
        else if (cmd.deg_wr_inc)
        begin
            deg_waddr = lab_reg;
            deg_wdata = deg_rdata + DEG_W'(1);
        end
        else if (cmd.deg_wr_dec)
        begin
            deg_waddr = lab_reg;
            deg_wdata = deg_rdata - DEG_W'(1);
        end
        else
        begin
            deg_waddr = leaf_reg;
            deg_wdata = '0;
        end
        deg_raddr = cmd.deg_rd_lab ? lab_reg : scan_reg[DEG_AW-1:0];
    end

    pstd_ram #(
        .WIDTH (DEG_W),
        .DEPTH (MAX_NODES)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    // leaf scan: one address issued a cycle, its degree checked the cycle after
    assign scan_issue = cmd.scan_run && (scan_reg < node_count_reg);
    assign scan_found = pipe_vld_reg && (deg_rdata == DEG_W'(1));
    assign scan_empty = !pipe_vld_reg && (scan_reg >= node_count_reg);

    always_comb
    begin
        pushed_count_next = pushed_count_reg;
        bad_flag_next     = bad_flag_reg;
        if (cmd.clr_run)
        begin
            pushed_count_next = '0;
            bad_flag_next     = 1'b0;
        end
        else if (cmd.push)
        begin
            if (store_full)
            begin
                bad_flag_next = 1'b1;
            end
            else
            begin
                pushed_count_next = pushed_count_reg + NODE_W'(1);
            end
        end

        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + DEG_AW'(1);
        end

        scan_next     = scan_reg;
        pipe_vld_next = pipe_vld_reg;
        if (cmd.scan_start)
        begin
            scan_next     = '0;
            pipe_vld_next = 1'b0;
        end
        else if (cmd.scan_run)
        begin
            pipe_vld_next = scan_issue;
            if (scan_issue)
            begin
                scan_next = scan_reg + NODE_W'(1);
            end
        end

        out_vld_next = out_vld_reg;
        if (cmd.emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= '0;
            pushed_count_reg <= '0;
            bad_flag_reg     <= 1'b0;
            idx_reg          <= '0;
            scan_reg         <= '0;
            pipe_vld_reg     <= 1'b0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            pushed_count_reg <= pushed_count_next;
            bad_flag_reg     <= bad_flag_next;
            idx_reg          <= idx_next;
            scan_reg         <= scan_next;
            pipe_vld_reg     <= pipe_vld_next;
            out_vld_reg      <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_addr_reg <= scan_reg[DEG_AW-1:0];
        if (cmd.lab_ld)
        begin
            lab_reg <= seq_rdata;
        end
        if (cmd.scan_run)
        begin
            if (scan_found)
            begin
                leaf_reg <= pipe_addr_reg;
            end
            else if (scan_empty)
            begin
                // no leaf left: take vertex 0
                leaf_reg <= '0;
            end
        end
        if (cmd.first_ld)
        begin
            first_reg <= leaf_reg;
        end
        if (cmd.emit)
        begin
            unique case (cmd.emit_kind)
                EMIT_EDGE:
                begin
                    out_first_reg  <= leaf_reg;
                    out_second_reg <= lab_reg;
                    out_status_reg <= STATUS_EDGE;
                    out_last_reg   <= 1'b0;
                end
                EMIT_FINAL:
                begin
                    out_first_reg  <= first_reg;
                    out_second_reg <= leaf_reg;
                    out_status_reg <= STATUS_EDGE;
                    out_last_reg   <= 1'b1;
                end
                EMIT_TINY:
                begin
                    out_first_reg  <= '0;
                    out_second_reg <= '0;
                    out_status_reg <= STATUS_TINY;
                    out_last_reg   <= 1'b1;
                end
                default:
                begin
                    out_first_reg  <= '0;
                    out_second_reg <= '0;
                    out_status_reg <= STATUS_BAD;
                    out_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.pre_bad  = bad_flag_reg || (node_count_reg > NODE_W'(MAX_NODES))
                        || ((node_count_reg >= NODE_W'(2))
                            ? (pushed_count_reg != node_count_reg - NODE_W'(2))
                            : (pushed_count_reg != '0));
        stat.n_le1    = (node_count_reg < NODE_W'(2));
        stat.n_is2    = (node_count_reg == NODE_W'(2));
        stat.seq_last = ((NODE_W'(idx_reg) + NODE_W'(3)) == node_count_reg);
        stat.deg_last = (idx_reg == DEG_AW'(MAX_NODES - 1));
        stat.lab_big  = (NODE_W'(seq_rdata) >= node_count_reg);
        stat.scan_end = scan_found || scan_empty;
        stat.out_free = !out_vld_reg || out_ready;
    end

    assign out_valid  = out_vld_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

### src/pstd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstd_ctrl: sequencing state machine of the decoder
// Accepts items, steps the datapath through check, initialise, count, leaf scans and emit.
// ----------------------------------------------------------------------------
module pstd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_opcode,
    input  pstd_pkg::stat_t stat,
    output pstd_pkg::cmd_t  cmd
);

    import pstd_pkg::*;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_DEC       = 5'd1;
    localparam logic [4:0] ST_CHK_RD    = 5'd2;
    localparam logic [4:0] ST_CHK_TEST  = 5'd3;
    localparam logic [4:0] ST_INIT      = 5'd4;
    localparam logic [4:0] ST_CNT_RD    = 5'd5;
    localparam logic [4:0] ST_CNT_LAB   = 5'd6;
    localparam logic [4:0] ST_CNT_DRD   = 5'd7;
    localparam logic [4:0] ST_CNT_WR    = 5'd8;
    localparam logic [4:0] ST_RUN_RD    = 5'd9;
    localparam logic [4:0] ST_RUN_LAB   = 5'd10;
    localparam logic [4:0] ST_RUN_SCAN  = 5'd11;
    localparam logic [4:0] ST_RUN_EMIT  = 5'd12;
    localparam logic [4:0] ST_RUN_DRD   = 5'd13;
    localparam logic [4:0] ST_RUN_DWR   = 5'd14;
    localparam logic [4:0] ST_FIN_USCAN = 5'd15;
    localparam logic [4:0] ST_FIN_UZERO = 5'd16;
    localparam logic [4:0] ST_FIN_WSCAN = 5'd17;
    localparam logic [4:0] ST_FIN_EMIT  = 5'd18;
    localparam logic [4:0] ST_EMIT_BAD  = 5'd19;
    localparam logic [4:0] ST_EMIT_TINY = 5'd20;

    logic [4:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_opcode == OP_PUSH)
                    begin
                        cmd.push = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_DEC:
            begin
                cmd.idx_clr = 1'b1;
                priority if (stat.pre_bad)
                begin
                    state_next = ST_EMIT_BAD;
                end
                else if (stat.n_le1)
                begin
                    state_next = ST_EMIT_TINY;
                end
                else if (stat.n_is2)
                begin
                    state_next = ST_INIT;
                end
                else
                begin
                    state_next = ST_CHK_RD;
                end
            end
            ST_CHK_RD:
            begin
                state_next = ST_CHK_TEST;
            end
            ST_CHK_TEST:
            begin
                priority if (stat.lab_big)
                begin
                    state_next = ST_EMIT_BAD;
                end
                else if (stat.seq_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_INIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_CHK_RD;
                end
            end
            ST_INIT:
            begin
                cmd.deg_init_wr = 1'b1;
                if (stat.deg_last)
                begin
                    cmd.idx_clr = 1'b1;
                    if (stat.n_is2)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_FIN_USCAN;
                    end
                    else
                    begin
                        state_next = ST_CNT_RD;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_CNT_RD:
            begin
                state_next = ST_CNT_LAB;
            end
            ST_CNT_LAB:
            begin
                cmd.lab_ld = 1'b1;
                state_next = ST_CNT_DRD;
            end
            ST_CNT_DRD:
            begin
                cmd.deg_rd_lab = 1'b1;
                state_next     = ST_CNT_WR;
            end
            ST_CNT_WR:
            begin
                cmd.deg_wr_inc = 1'b1;
                if (stat.seq_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_RUN_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_CNT_RD;
                end
            end
            ST_RUN_RD:
            begin
                state_next = ST_RUN_LAB;
            end
            ST_RUN_LAB:
            begin
                cmd.lab_ld     = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = ST_RUN_SCAN;
            end
            ST_RUN_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = ST_RUN_EMIT;
                end
            end
            ST_RUN_EMIT:
            begin
                // hold until the output register can take the edge
                if (stat.out_free)
                begin
                    cmd.emit             = 1'b1;
                    cmd.emit_kind        = EMIT_EDGE;
                    cmd.deg_wr_leaf_zero = 1'b1;
                    state_next           = ST_RUN_DRD;
                end
            end
            ST_RUN_DRD:
            begin
                cmd.deg_rd_lab = 1'b1;
                state_next     = ST_RUN_DWR;
            end
            ST_RUN_DWR:
            begin
                cmd.deg_wr_dec = 1'b1;
                if (stat.seq_last)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_FIN_USCAN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_RUN_RD;
                end
            end
            ST_FIN_USCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = ST_FIN_UZERO;
                end
            end
            ST_FIN_UZERO:
            begin
                cmd.first_ld         = 1'b1;
                cmd.deg_wr_leaf_zero = 1'b1;
                cmd.scan_start       = 1'b1;
                state_next           = ST_FIN_WSCAN;
            end
            ST_FIN_WSCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = ST_FIN_EMIT;
                end
            end
            ST_FIN_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_FINAL;
                    cmd.clr_run   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_BAD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_BAD;
                    cmd.clr_run   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT_TINY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_TINY;
                    cmd.clr_run   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/prufer_sequence_tree_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prufer_sequence_tree_decoder: Pruefer sequence to labelled tree edges
// Push items load labels; a decode item emits the node_count-1 tree edges,
// or a single tiny-tree or bad-sequence result.
//   channel  direction  payload
//   s_*      in         tuser = opcode, tdata = label
//   m_*      out        tdata = edge_first, edge_second; tuser = status;
//                       tlast = last
//   cfg_*    in         cfg_data = node_count
//
// A push item is taken in the idle state. A decode item is accepted, then the
// count checks run, each label is range-checked, every entry of the degree
// table is initialised and the degrees of the labels are counted; each edge
// is then found by a leaf scan that reads one degree entry a cycle, and the
// final edge by two such scans.
// Reset clears all control state; no clearing pass is needed.
// A stalled m_tready holds the sequencer only when the next result item is
// ready while the previous one still waits.
// ----------------------------------------------------------------------------
module prufer_sequence_tree_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] label, [7:6] zero
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] edge_first, [11:6] edge_second, [15:12] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    import pstd_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [LABEL_W-1:0]  out_first, out_second;
    logic [STATUS_W-1:0] out_status;

    assign cfg_ready = 1'b1;

    pstd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .stat      (stat),
        .cmd       (cmd)
    );

    pstd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_label   (s_tdata[LABEL_W-1:0]),
        .cfg_we     (cfg_valid),
        .cfg_wdata  (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_first  (out_first),
        .out_second (out_second),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, out_second, out_first};
    assign m_tuser = out_status;

endmodule

### verif/prufer_sequence_tree_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prufer_sequence_tree_decoder_tb: self-checking bench for the tree decoder
// Pushes label sequences and decode items under random stalls on both
// streams. Each accepted decode is predicted in the bench and every emitted
// edge, tiny-tree marker and error result is checked in order.
// ----------------------------------------------------------------------------
module prufer_sequence_tree_decoder_tb;

    import pstd_pkg::*;

    localparam int SETTLE      = 32;
    localparam int DRAIN       = 200;
    localparam int IDLE_LIMIT  = 20000;
    localparam int RAND_ITEMS  = 24;

    // ways a run of labels can be spoilt
    localparam int FLAW_NONE     = 0;
    localparam int FLAW_SHORT    = 1;
    localparam int FLAW_LONG     = 2;
    localparam int FLAW_RANGE    = 3;
    localparam int FLAW_OVERFLOW = 4;

    typedef struct packed {
        logic             op;
        logic [LABEL_W-1:0] label;
    } seq_item_t;

    typedef struct {
        bit [LABEL_W-1:0]  first;
        bit [LABEL_W-1:0]  second;
        bit [STATUS_W-1:0] status;
        bit                last;
    } tree_link_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [5:0] label, [7:6] zero
    logic        s_tuser = 1'b0;  // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [5:0] edge_first, [11:6] edge_second, [15:12] zero
    logic [1:0]  m_tuser;         // [1:0] status
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;

    prufer_sequence_tree_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    seq_item_t  seq_items[$];
    tree_link_t pending_links[$];

    // shadow of the decoder state
    bit [NODE_W-1:0]  node_cnt;
    bit [LABEL_W-1:0] seq_mem[SEQ_DEPTH];
    bit [DEG_W-1:0]   deg_tab[MAX_NODES];
    int unsigned      pushed;
    bit               bad_flag;

    int unsigned fails;
    int unsigned n_decodes, n_edges, n_tiny, n_bad, n_settings;
    int unsigned idle_cycles;
    int unsigned small_items;
    tree_link_t  want;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit [LABEL_W-1:0] lowest_leaf(int unsigned n);
        for (int unsigned v = 0; v < n && v < MAX_NODES; v++)
            if (deg_tab[v] == 1)
                return v[LABEL_W-1:0];
        return '0;
    endfunction

    task automatic predict_links(logic op, logic [LABEL_W-1:0] lab);
        int unsigned      n;
        bit               bad;
        bit [LABEL_W-1:0] a, v, u, w;
        n = node_cnt;
        if (op == OP_PUSH)
        begin
            // a 6-bit label can never reach MAX_NODES; only overflow flags here
            if (pushed >= SEQ_DEPTH)
                bad_flag = 1'b1;
            else
            begin
                seq_mem[pushed] = lab;
                pushed++;
            end
            return;
        end
        n_decodes++;
        bad = bad_flag || (n > MAX_NODES);
        if (!bad)
            bad = (n >= 2) ? (pushed != n - 2) : (pushed != 0);
        if (!bad)
            for (int unsigned i = 0; i < pushed && i < SEQ_DEPTH; i++)
                if (seq_mem[i] >= n)
                    bad = 1'b1;
        pushed = 0;
        bad_flag = 1'b0;
        if (bad)
        begin
            pending_links.push_back('{first: '0, second: '0, status: STATUS_BAD, last: 1'b1});
            return;
        end
        if (n <= 1)
        begin
            pending_links.push_back('{first: '0, second: '0, status: STATUS_TINY, last: 1'b1});
            return;
        end
        foreach (deg_tab[i])
            deg_tab[i] = (i < n) ? DEG_W'(1) : DEG_W'(0);
        for (int unsigned i = 0; i < n - 2; i++)
            deg_tab[seq_mem[i]] = deg_tab[seq_mem[i]] + DEG_W'(1);
        for (int unsigned i = 0; i < n - 2; i++)
        begin
            a = seq_mem[i];
            v = lowest_leaf(n);
            pending_links.push_back('{first: v, second: a, status: STATUS_EDGE, last: 1'b0});
            deg_tab[v] = 0;
            deg_tab[a] = deg_tab[a] - DEG_W'(1);
        end
        // join the last two leaves, smaller first
        u = lowest_leaf(n);
        deg_tab[u] = 0;
        w = lowest_leaf(n);
        deg_tab[w] = 0;
        pending_links.push_back('{first: u, second: w, status: STATUS_EDGE, last: 1'b1});
    endtask

    // ---------------- stimulus driver ----------------
    int unsigned s_gap;
    bit          s_quiet;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_gap    <= 0;
            s_quiet  <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                s_quiet <= ~s_quiet;
            if (!s_tvalid || s_tready)
            begin
                if (s_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    s_gap    <= s_gap - 1;
                end
                else if (seq_items.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, seq_items[0].label};
                    s_tuser  <= seq_items[0].op;
                    s_gap    <= s_quiet ? 0 : pick_gap();
                    void'(seq_items.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result back-pressure ----------------
    int unsigned m_hold;
    bit          m_quiet;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            m_hold   <= 0;
            m_quiet  <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                m_quiet <= ~m_quiet;
            if (m_hold > 0)
            begin
                m_tready <= 1'b0;
                m_hold   <= m_hold - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                m_hold   <= m_quiet ? 0 : pick_gap();
            end
        end
    end

    // ---------------- monitor, checker and watchdog ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                node_cnt = cfg_data;
            if (s_tvalid && s_tready)
                predict_links(s_tuser, s_tdata[LABEL_W-1:0]);
            if (m_tvalid && m_tready)
            begin
                if (pending_links.size() == 0)
                begin
                    $error("unexpected result: first %0d second %0d status %0d last %0d",
                           m_tdata[5:0], m_tdata[11:6], m_tuser, m_tlast);
                    fails++;
                end
                else
                begin
                    want = pending_links.pop_front();
                    if (m_tdata[5:0] !== want.first)
                    begin
                        $error("edge_first: expected %0d, got %0d", want.first, m_tdata[5:0]);
                        fails++;
                    end
                    if (m_tdata[11:6] !== want.second)
                    begin
                        $error("edge_second: expected %0d, got %0d", want.second, m_tdata[11:6]);
                        fails++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fails++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        fails++;
                    end
                    case (want.status)
                        STATUS_EDGE: n_edges++;
                        STATUS_TINY: n_tiny++;
                        default:     n_bad++;
                    endcase
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------- stimulus plan ----------------
    task automatic wait_idle();
        do
        begin
            do
                @(posedge clk);
            while (seq_items.size() != 0 || s_tvalid || pending_links.size() != 0);
            // a trailing push leaves no result to wait on; let it settle
            repeat (SETTLE) @(posedge clk);
        end
        // an item taken from the queue on the last sampled edge may still be in flight
        while (seq_items.size() != 0 || s_tvalid || pending_links.size() != 0);
    endtask

    task automatic set_count(int unsigned n);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= n[NODE_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic queue_item(logic op, int unsigned lab);
        seq_items.push_back('{op: op, label: lab[LABEL_W-1:0]});
    endtask

    // queue one run of labels followed by a decode; returns items queued
    task automatic add_run(int unsigned n, int flaw, output int unsigned count);
        int unsigned len, bad_pos, lab_hi;
        len = (n >= 2) ? n - 2 : 0;
        case (flaw)
            FLAW_SHORT:    len = (len > 0) ? len - 1 : 1;
            FLAW_LONG:     len = len + 1;
            FLAW_OVERFLOW: len = SEQ_DEPTH + 1;
            default:       ;
        endcase
        bad_pos = (flaw == FLAW_RANGE && n < MAX_NODES && len > 0)
                  ? $urandom_range(0, len - 1) : len;
        lab_hi = (n == 0 || n > MAX_NODES) ? MAX_NODES - 1 : n - 1;
        for (int unsigned i = 0; i < len; i++)
            queue_item(OP_PUSH, (i == bad_pos) ? $urandom_range(n, MAX_NODES - 1)
                                               : $urandom_range(0, lab_hi));
        queue_item(OP_DECODE, $urandom_range(0, MAX_NODES - 1));
        count = len + 1;
    endtask

    initial
    begin
        int unsigned n, runs, cnt, r;
        int          flaw;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // tiny tree straight out of reset, node count still zero
        queue_item(OP_DECODE, 0);
        set_count(1);
        queue_item(OP_DECODE, 63);
        queue_item(OP_PUSH, 0);           // labels on a tiny tree: error
        queue_item(OP_DECODE, 0);
        set_count(0);
        queue_item(OP_PUSH, 63);
        queue_item(OP_DECODE, 0);
        set_count(2);
        queue_item(OP_DECODE, 0);         // single edge 0-1
        queue_item(OP_PUSH, 1);           // wrong label count
        queue_item(OP_DECODE, 0);
        set_count(5);
        queue_item(OP_PUSH, 4);
        queue_item(OP_PUSH, 4);
        queue_item(OP_PUSH, 0);
        queue_item(OP_DECODE, 0);
        queue_item(OP_PUSH, 2);
        queue_item(OP_PUSH, 63);          // label beyond node count
        queue_item(OP_PUSH, 1);
        queue_item(OP_DECODE, 0);
        set_count(127);                   // node count above the maximum
        queue_item(OP_DECODE, 0);

        // largest tree, then a store overflow
        set_count(MAX_NODES);
        add_run(MAX_NODES, FLAW_NONE, cnt);
        add_run(MAX_NODES, FLAW_OVERFLOW, cnt);

        small_items = 0;
        while (small_items < RAND_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                n = $urandom_range(0, 1);
            else if (r < 80)
                n = $urandom_range(2, 9);
            else
                n = $urandom_range(10, 24);
            set_count(n);
            runs = $urandom_range(2, 5);
            repeat (runs)
            begin
                if (small_items < RAND_ITEMS)
                begin
                    flaw = ($urandom_range(0, 99) < 75) ? FLAW_NONE
                                                       : $urandom_range(FLAW_SHORT, FLAW_RANGE);
                    add_run(n, flaw, cnt);
                    small_items += cnt;
                end
            end
        end

        wait_idle();
        repeat (DRAIN) @(posedge clk);
        $display("covered %0d decodes over %0d node-count settings", n_decodes, n_settings);
        $display("results: %0d edges, %0d tiny-tree, %0d bad-sequence", n_edges, n_tiny, n_bad);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### prufer_sequence_tree_decoder.f
src/pstd_pkg.sv
src/pstd_ram.sv
src/pstd_datapath.sv
src/pstd_ctrl.sv
src/prufer_sequence_tree_decoder.sv
verif/prufer_sequence_tree_decoder_tb.sv
